FILE: hdl/c8core_pkg.sv
// ----------------------------------------------------------------------------
// c8core_pkg
// Shared types, codes and the hex font table of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8core_pkg;

    // Default sizes
    localparam int unsigned MEM_BYTES_DEF   = 4096;
    localparam int unsigned STACK_DEPTH_DEF = 16;

    // Input item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // Result kinds
    localparam logic [1:0] RES_DONE  = 2'd0;
    localparam logic [1:0] RES_ROW   = 2'd1;
    localparam logic [1:0] RES_CLEAR = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_STACK   = 2'd2;

    // Configuration register byte addresses
    localparam logic [0:0] REG_START_ADDRESS = 1'b0;
    localparam logic [11:0] START_ADDRESS_RST = 12'h200;

    // Opcode groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // ALU sub-ops
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // System, key and misc low bytes
    localparam logic [11:0] SYS_CLS = 12'h0E0;
    localparam logic [11:0] SYS_RET = 12'h0EE;
    localparam logic [7:0] KEY_SKP   = 8'h9E;
    localparam logic [7:0] KEY_SKNP  = 8'hA1;
    localparam logic [7:0] MISC_GDT  = 8'h07;
    localparam logic [7:0] MISC_WKEY = 8'h0A;
    localparam logic [7:0] MISC_SDT  = 8'h15;
    localparam logic [7:0] MISC_SST  = 8'h18;
    localparam logic [7:0] MISC_ADDI = 8'h1E;
    localparam logic [7:0] MISC_FONT = 8'h29;
    localparam logic [7:0] MISC_BCD  = 8'h33;
    localparam logic [7:0] MISC_STR  = 8'h55;
    localparam logic [7:0] MISC_LDR  = 8'h65;

    // Access command for a storage port
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

    // Hex font, five bytes per digit
    localparam int unsigned FONT_BYTES = 80;
    localparam logic [7:0] FONT_ROM [0:79] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

FILE: hdl/c8core_in_if.sv
// ----------------------------------------------------------------------------
// c8core_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface c8core_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys_pressed;
    logic [7:0]  random_byte;
    logic        draw_collision;

    modport source (
        output valid, kind, address, data, keys_pressed, random_byte, draw_collision,
        input  ready
    );
    modport sink (
        input  valid, kind, address, data, keys_pressed, random_byte, draw_collision,
        output ready
    );
endinterface

FILE: hdl/c8core_out_if.sv
// ----------------------------------------------------------------------------
// c8core_out_if
// Result item channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface c8core_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [11:0] program_counter;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  row_index;
    logic [7:0]  row_bits;
    logic        sound_active;
    logic        last;

    modport source (
        output valid, result_kind, status, program_counter, draw_x, draw_y,
               row_index, row_bits, sound_active, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, status, program_counter, draw_x, draw_y,
               row_index, row_bits, sound_active, last,
        output ready
    );
endinterface

FILE: hdl/chip8_instruction_core_unit.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core_unit
// CHIP-8 core: sequencer around the main memory and the register file.
// ----------------------------------------------------------------------------
// Each item is handled one at a time by a sequencer that reads and writes
// the main memory and the V register file through single ports with a
// registered read. A load, tick or unused item goes straight to the result
// state; a step fetches with two memory reads, then makes two register reads,
// with a return state for 00EE, a write-back state for the 8xy4..8xyE ops
// that set VF, a write per digit for BCD and a read and a write per register
// for Fx55/Fx65. Dxyn reads the sprite row by row, each row being one result
// item. A finished result waits in an output register, so the next item is
// taken while it is pending; a result that cannot be handed over holds the
// sequencer until the receiver takes the previous one. After reset no item is
// accepted while memory clears; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module chip8_instruction_core_unit
    import c8core_pkg::*;
#(
    parameter int unsigned MEM_BYTES   = MEM_BYTES_DEF,
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    c8core_in_if.sink    in_ch,
    c8core_out_if.source out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int unsigned AW  = $clog2(MEM_BYTES);
    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SIW = $clog2(STACK_DEPTH);
    localparam int unsigned RSH = 34;
    localparam logic [63:0] RECIP = (64'd1 << RSH) / 64'(MEM_BYTES);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_F1   = 16'h0002,
        S_F2   = 16'h0004,
        S_RX   = 16'h0008,
        S_RY   = 16'h0010,
        S_EXEC = 16'h0020,
        S_WB   = 16'h0040,
        S_RET  = 16'h0080,
        S_BCD  = 16'h0100,
        S_STRD = 16'h0200,
        S_STWR = 16'h0400,
        S_LDRD = 16'h0800,
        S_LDWR = 16'h1000,
        S_DRRD = 16'h2000,
        S_DRAW = 16'h4000,
        S_DONE = 16'h8000
    } state_t;

    // Byte address modulo MEM_BYTES by reciprocal multiply and one correction
    function automatic logic [AW-1:0] wrap_addr(input logic [16:0] a);
        logic [63:0] p;
        logic [16:0] q;
        logic [16:0] r;
        p = {47'd0, a} * RECIP;
        q = p[RSH+16:RSH];
        r = a - 17'(q * 17'(MEM_BYTES));
        if (r >= 17'(MEM_BYTES))
        begin
            r = r - 17'(MEM_BYTES);
        end
        return r[AW-1:0];
    endfunction

    state_t      state_reg, state_next;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] start_reg, start_next;
    logic [15:0] i_reg, i_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  st_reg, st_next;
    logic        halt_reg, halt_next;
    logic [1:0]  cause_reg, cause_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic        col_reg, col_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  wb_reg, wb_next;
    logic [1:0]  rkind_reg, rkind_next;
    logic [1:0]  rstat_reg, rstat_next;

    logic        ovld_reg, ovld_next;
    logic [1:0]  okind_reg, okind_next;
    logic [1:0]  ostat_reg, ostat_next;
    logic [11:0] opc_reg, opc_next;
    logic [7:0]  ox_reg, ox_next;
    logic [7:0]  oy_reg, oy_next;
    logic [3:0]  orow_reg, orow_next;
    logic [7:0]  obits_reg, obits_next;
    logic        osnd_reg, osnd_next;
    logic        olast_reg, olast_next;

    mem_cmd_t    mem_cmd;
    logic [AW-1:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_rdata;
    logic        mem_busy;
    mem_cmd_t    rf_cmd;
    logic [3:0]  rf_raddr;
    logic [3:0]  rf_waddr;
    logic [7:0]  rf_wdata;
    logic [7:0]  rf_rdata;

    logic [11:0] stk_mem [STACK_DEPTH];
    logic [11:0] stk_rdata_reg;
    logic        stk_wr;
    logic        stk_rd;
    logic [SIW-1:0] stk_waddr;
    logic [SIW-1:0] stk_raddr;
    logic [SPW-1:0] sp_dec;

    logic        in_acc;
    logic        slot_free;
    logic        cfg_wr;
    logic [3:0]  op;
    logic [3:0]  rx;
    logic [3:0]  ry;
    logic [3:0]  nib;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [11:0] pc2;
    logic [11:0] pc4;
    logic [16:0] i_off;
    logic [3:0]  key_num;
    logic        key_down;
    logic [8:0]  add_sum;
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_r;
    logic [14:0] bcd_p;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_o;
    logic [7:0]  bcd_digit;

    // Storage blocks
    c8core_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    c8core_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rf_cmd),
        .raddr (rf_raddr),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .rdata (rf_rdata)
    );

    // Return stack
    always_ff @(posedge clk)
    begin
        if (stk_wr)
        begin
            stk_mem[stk_waddr] <= pc2;
        end
        if (stk_rd)
        begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    // Decode fields and helpers
    always_comb
    begin
        op      = hi_reg[7:4];
        rx      = hi_reg[3:0];
        ry      = lo_reg[7:4];
        nib     = lo_reg[3:0];
        kk      = lo_reg;
        nnn     = {hi_reg[3:0], lo_reg};
        pc2     = pc_reg + 12'd2;
        pc4     = pc_reg + 12'd4;
        i_off   = {1'b0, i_reg} + {13'd0, cnt_reg};
        sp_dec  = sp_reg - SPW'(1);
        stk_waddr = sp_reg[SIW-1:0];
        stk_raddr = sp_dec[SIW-1:0];
        key_down = keys_reg[vx_reg[3:0]];
        add_sum = {1'b0, vx_reg} + {1'b0, vy_reg};
        // lowest pressed key
        key_num = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                key_num = 4'(k);
            end
        end
        // BCD digits
        if (vx_reg >= 8'd200)
        begin
            bcd_h = 2'd2;
            bcd_r = vx_reg - 8'd200;
        end
        else if (vx_reg >= 8'd100)
        begin
            bcd_h = 2'd1;
            bcd_r = vx_reg - 8'd100;
        end
        else
        begin
            bcd_h = 2'd0;
            bcd_r = vx_reg;
        end
        bcd_p = 15'(bcd_r[6:0]) * 15'd205;
        bcd_t = bcd_p[14:11];
        bcd_o = bcd_r - 8'(bcd_t) * 8'd10;
        case (cnt_reg[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = bcd_o;
        endcase
    end

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign slot_free = !ovld_reg || out_ch.ready;
    assign cfg_wr    = psel && penable && pwrite && (paddr == REG_START_ADDRESS);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        start_next = start_reg;
        i_next     = i_reg;
        sp_next    = sp_reg;
        dt_next    = dt_reg;
        st_next    = st_reg;
        halt_next  = halt_reg;
        cause_next = cause_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        keys_next  = keys_reg;
        rnd_next   = rnd_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        wb_next    = wb_reg;
        rkind_next = rkind_reg;
        rstat_next = rstat_reg;

        ovld_next  = ovld_reg && !out_ch.ready;
        okind_next = okind_reg;
        ostat_next = ostat_reg;
        opc_next   = opc_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        orow_next  = orow_reg;
        obits_next = obits_reg;
        osnd_next  = osnd_reg;
        olast_next = olast_reg;

        mem_cmd   = '0;
        mem_addr  = '0;
        mem_wdata = 8'h00;
        rf_cmd    = '0;
        rf_raddr  = 4'd0;
        rf_waddr  = rx;
        rf_wdata  = 8'h00;
        stk_wr    = 1'b0;
        stk_rd    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    rkind_next = RES_DONE;
                    rstat_next = ST_OK;
                    state_next = S_DONE;
                    case (in_ch.kind)
                        KIND_LOAD:
                        begin
                            mem_cmd.wr = 1'b1;
                            mem_addr   = wrap_addr({5'd0, in_ch.address});
                            mem_wdata  = in_ch.data;
                        end
                        KIND_TICK:
                        begin
                            if (dt_reg != 8'd0)
                            begin
                                dt_next = dt_reg - 8'd1;
                            end
                            if (st_reg != 8'd0)
                            begin
                                st_next = st_reg - 8'd1;
                            end
                        end
                        KIND_STEP:
                        begin
                            if (halt_reg)
                            begin
                                rstat_next = cause_reg;
                            end
                            else
                            begin
                                keys_next   = in_ch.keys_pressed;
                                rnd_next    = in_ch.random_byte;
                                col_next    = in_ch.draw_collision;
                                mem_cmd.rd  = 1'b1;
                                mem_addr    = wrap_addr({5'd0, pc_reg});
                                state_next  = S_F1;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_F1:
            begin
                hi_next    = mem_rdata;
                mem_cmd.rd = 1'b1;
                mem_addr   = wrap_addr({5'd0, pc_reg} + 17'd1);
                state_next = S_F2;
            end

            S_F2:
            begin
                lo_next    = mem_rdata;
                rf_cmd.rd  = 1'b1;
                rf_raddr   = rx;
                state_next = S_RX;
            end

            S_RX:
            begin
                vx_next    = rf_rdata;
                rf_cmd.rd  = 1'b1;
                rf_raddr   = (op == OP_JPV) ? 4'd0 : ry;
                state_next = S_RY;
            end

            S_RY:
            begin
                vy_next    = rf_rdata;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                pc_next    = pc2;
                state_next = S_DONE;
                rf_waddr   = rx;
                case (op)
                    OP_SYS:
                    begin
                        if (nnn == SYS_CLS)
                        begin
                            rkind_next = RES_CLEAR;
                        end
                        else if (nnn == SYS_RET)
                        begin
                            if (sp_reg == '0)
                            begin
                                pc_next    = pc_reg;
                                halt_next  = 1'b1;
                                cause_next = ST_STACK;
                                rstat_next = ST_STACK;
                            end
                            else
                            begin
                                sp_next    = sp_dec;
                                stk_rd     = 1'b1;
                                state_next = S_RET;
                            end
                        end
                        else
                        begin
                            pc_next    = pc_reg;
                            halt_next  = 1'b1;
                            cause_next = ST_ILLEGAL;
                            rstat_next = ST_ILLEGAL;
                        end
                    end
                    OP_JP:
                    begin
                        pc_next = nnn;
                    end
                    OP_CALL:
                    begin
                        if (sp_reg >= SPW'(STACK_DEPTH))
                        begin
                            pc_next    = pc_reg;
                            halt_next  = 1'b1;
                            cause_next = ST_STACK;
                            rstat_next = ST_STACK;
                        end
                        else
                        begin
                            stk_wr  = 1'b1;
                            sp_next = sp_reg + SPW'(1);
                            pc_next = nnn;
                        end
                    end
                    OP_SE:
                    begin
                        if (vx_reg == kk)
                        begin
                            pc_next = pc4;
                        end
                    end
                    OP_SNE:
                    begin
                        if (vx_reg != kk)
                        begin
                            pc_next = pc4;
                        end
                    end
                    OP_SER:
                    begin
                        if (vx_reg == vy_reg)
                        begin
                            pc_next = pc4;
                        end
                    end
                    OP_SNER:
                    begin
                        if (vx_reg != vy_reg)
                        begin
                            pc_next = pc4;
                        end
                    end
                    OP_LD:
                    begin
                        rf_cmd.wr = 1'b1;
                        rf_wdata  = kk;
                    end
                    OP_ADD:
                    begin
                        rf_cmd.wr = 1'b1;
                        rf_wdata  = vx_reg + kk;
                    end
                    OP_ALU:
                    begin
                        // flag goes first, the result follows in write-back
                        rf_waddr   = 4'hF;
                        state_next = S_WB;
                        case (nib)
                            ALU_MOV:
                            begin
                                rf_waddr   = rx;
                                rf_cmd.wr  = 1'b1;
                                rf_wdata   = vy_reg;
                                state_next = S_DONE;
                            end
                            ALU_OR:
                            begin
                                rf_waddr   = rx;
                                rf_cmd.wr  = 1'b1;
                                rf_wdata   = vx_reg | vy_reg;
                                state_next = S_DONE;
                            end
                            ALU_AND:
                            begin
                                rf_waddr   = rx;
                                rf_cmd.wr  = 1'b1;
                                rf_wdata   = vx_reg & vy_reg;
                                state_next = S_DONE;
                            end
                            ALU_XOR:
                            begin
                                rf_waddr   = rx;
                                rf_cmd.wr  = 1'b1;
                                rf_wdata   = vx_reg ^ vy_reg;
                                state_next = S_DONE;
                            end
                            ALU_ADD:
                            begin
                                rf_cmd.wr = 1'b1;
                                rf_wdata  = {7'd0, add_sum[8]};
                                wb_next   = add_sum[7:0];
                            end
                            ALU_SUB:
                            begin
                                rf_cmd.wr = 1'b1;
                                rf_wdata  = {7'd0, vx_reg > vy_reg};
                                wb_next   = vx_reg - vy_reg;
                            end
                            ALU_SHR:
                            begin
                                rf_cmd.wr = 1'b1;
                                rf_wdata  = {7'd0, vx_reg[0]};
                                wb_next   = {1'b0, vx_reg[7:1]};
                            end
                            ALU_SBN:
                            begin
                                rf_cmd.wr = 1'b1;
                                rf_wdata  = {7'd0, vy_reg > vx_reg};
                                wb_next   = vy_reg - vx_reg;
                            end
                            ALU_SHL:
                            begin
                                rf_cmd.wr = 1'b1;
                                rf_wdata  = {7'd0, vx_reg[7]};
                                wb_next   = {vx_reg[6:0], 1'b0};
                            end
                            default:
                            begin
                                pc_next    = pc_reg;
                                halt_next  = 1'b1;
                                cause_next = ST_ILLEGAL;
                                rstat_next = ST_ILLEGAL;
                                state_next = S_DONE;
                            end
                        endcase
                    end
                    OP_LDI:
                    begin
                        i_next = {4'd0, nnn};
                    end
                    OP_JPV:
                    begin
                        pc_next = {4'd0, vy_reg} + nnn;
                    end
                    OP_RND:
                    begin
                        rf_cmd.wr = 1'b1;
                        rf_wdata  = rnd_reg & kk;
                    end
                    OP_DRW:
                    begin
                        rf_waddr  = 4'hF;
                        rf_cmd.wr = 1'b1;
                        rf_wdata  = {7'd0, col_reg};
                        cnt_next  = 4'd0;
                        if (nib != 4'd0)
                        begin
                            state_next = S_DRRD;
                        end
                    end
                    OP_KEY:
                    begin
                        if (kk == KEY_SKP)
                        begin
                            if (key_down)
                            begin
                                pc_next = pc4;
                            end
                        end
                        else if (kk == KEY_SKNP)
                        begin
                            if (!key_down)
                            begin
                                pc_next = pc4;
                            end
                        end
                        else
                        begin
                            pc_next    = pc_reg;
                            halt_next  = 1'b1;
                            cause_next = ST_ILLEGAL;
                            rstat_next = ST_ILLEGAL;
                        end
                    end
                    default:
                    begin
                        cnt_next = 4'd0;
                        case (kk)
                            MISC_GDT:
                            begin
                                rf_cmd.wr = 1'b1;
                                rf_wdata  = dt_reg;
                            end
                            MISC_WKEY:
                            begin
                                if (keys_reg == 16'd0)
                                begin
                                    pc_next = pc_reg;
                                end
                                else
                                begin
                                    rf_cmd.wr = 1'b1;
                                    rf_wdata  = {4'd0, key_num};
                                end
                            end
                            MISC_SDT:
                            begin
                                dt_next = vx_reg;
                            end
                            MISC_SST:
                            begin
                                st_next = vx_reg;
                            end
                            MISC_ADDI:
                            begin
                                i_next = i_reg + {8'd0, vx_reg};
                            end
                            MISC_FONT:
                            begin
                                i_next = 16'({4'd0, vx_reg[3:0]} * 8'd5);
                            end
                            MISC_BCD:
                            begin
                                state_next = S_BCD;
                            end
                            MISC_STR:
                            begin
                                state_next = S_STRD;
                            end
                            MISC_LDR:
                            begin
                                state_next = S_LDRD;
                            end
                            default:
                            begin
                                pc_next    = pc_reg;
                                halt_next  = 1'b1;
                                cause_next = ST_ILLEGAL;
                                rstat_next = ST_ILLEGAL;
                            end
                        endcase
                    end
                endcase
            end

            S_WB:
            begin
                rf_cmd.wr  = 1'b1;
                rf_waddr   = rx;
                rf_wdata   = wb_reg;
                state_next = S_DONE;
            end

            S_RET:
            begin
                pc_next    = stk_rdata_reg;
                state_next = S_DONE;
            end

            S_BCD:
            begin
                mem_cmd.wr = 1'b1;
                mem_addr   = wrap_addr(i_off);
                mem_wdata  = bcd_digit;
                cnt_next   = cnt_reg + 4'd1;
                if (cnt_reg == 4'd2)
                begin
                    state_next = S_DONE;
                end
            end

            S_STRD:
            begin
                rf_cmd.rd  = 1'b1;
                rf_raddr   = cnt_reg;
                state_next = S_STWR;
            end

            S_STWR:
            begin
                mem_cmd.wr = 1'b1;
                mem_addr   = wrap_addr(i_off);
                mem_wdata  = rf_rdata;
                cnt_next   = cnt_reg + 4'd1;
                state_next = (cnt_reg == rx) ? S_DONE : S_STRD;
            end

            S_LDRD:
            begin
                mem_cmd.rd = 1'b1;
                mem_addr   = wrap_addr(i_off);
                state_next = S_LDWR;
            end

            S_LDWR:
            begin
                rf_cmd.wr  = 1'b1;
                rf_waddr   = cnt_reg;
                rf_wdata   = mem_rdata;
                cnt_next   = cnt_reg + 4'd1;
                state_next = (cnt_reg == rx) ? S_DONE : S_LDRD;
            end

            S_DRRD:
            begin
                mem_cmd.rd = 1'b1;
                mem_addr   = wrap_addr(i_off);
                state_next = S_DRAW;
            end

            S_DRAW:
            begin
                // one sprite row per result item
                if (slot_free)
                begin
                    ovld_next  = 1'b1;
                    okind_next = RES_ROW;
                    ostat_next = ST_OK;
                    opc_next   = pc_reg;
                    ox_next    = vx_reg;
                    oy_next    = vy_reg;
                    orow_next  = cnt_reg;
                    obits_next = mem_rdata;
                    osnd_next  = (st_reg != 8'd0);
                    olast_next = (cnt_reg == nib - 4'd1);
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = (cnt_reg == nib - 4'd1) ? S_IDLE : S_DRRD;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    ovld_next  = 1'b1;
                    okind_next = rkind_reg;
                    ostat_next = rstat_reg;
                    opc_next   = pc_reg;
                    ox_next    = 8'h00;
                    oy_next    = 8'h00;
                    orow_next  = 4'd0;
                    obits_next = 8'h00;
                    osnd_next  = (st_reg != 8'd0);
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration write; the program counter follows the new entry point
        if (cfg_wr)
        begin
            start_next = pwdata[11:0];
            pc_next    = pwdata[11:0];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= START_ADDRESS_RST;
            start_reg <= START_ADDRESS_RST;
            i_reg     <= '0;
            sp_reg    <= '0;
            dt_reg    <= '0;
            st_reg    <= '0;
            halt_reg  <= 1'b0;
            cause_reg <= ST_OK;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            start_reg <= start_next;
            i_reg     <= i_next;
            sp_reg    <= sp_next;
            dt_reg    <= dt_next;
            st_reg    <= st_next;
            halt_reg  <= halt_next;
            cause_reg <= cause_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        keys_reg  <= keys_next;
        rnd_reg   <= rnd_next;
        col_reg   <= col_next;
        cnt_reg   <= cnt_next;
        wb_reg    <= wb_next;
        rkind_reg <= rkind_next;
        rstat_reg <= rstat_next;
        okind_reg <= okind_next;
        ostat_reg <= ostat_next;
        opc_reg   <= opc_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        orow_reg  <= orow_next;
        obits_reg <= obits_next;
        osnd_reg  <= osnd_next;
        olast_reg <= olast_next;
    end

    // Ports
    assign in_ch.ready            = (state_reg == S_IDLE) && !mem_busy;
    assign out_ch.valid           = ovld_reg;
    assign out_ch.result_kind     = okind_reg;
    assign out_ch.status          = ostat_reg;
    assign out_ch.program_counter = opc_reg;
    assign out_ch.draw_x          = ox_reg;
    assign out_ch.draw_y          = oy_reg;
    assign out_ch.row_index       = orow_reg;
    assign out_ch.row_bits        = obits_reg;
    assign out_ch.sound_active    = osnd_reg;
    assign out_ch.last            = olast_reg;
    assign prdata = (paddr == REG_START_ADDRESS) ? {20'd0, start_reg} : 32'd0;
    assign pready = 1'b1;
endmodule

FILE: hdl/c8core_mem.sv
// ----------------------------------------------------------------------------
// c8core_mem
// Main byte memory, single port, registered read. After reset a clearing
// pass writes the font and zeroes the rest, one byte per cycle.
// ----------------------------------------------------------------------------
module c8core_mem
    import c8core_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mem_cmd_t                     cmd,
    input  logic [$clog2(MEM_BYTES)-1:0] addr,
    input  logic [7:0]                   wdata,
    output logic [7:0]                   rdata,
    output logic                         busy
);
    localparam int unsigned AW = $clog2(MEM_BYTES);

    logic [7:0]    mem [MEM_BYTES];
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          clr_reg;
    logic          clr_next;
    logic [7:0]    rdata_reg;
    logic [7:0]    clr_byte;

    // Clearing pass sequencing
    always_comb
    begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MEM_BYTES - 1))
            begin
                clr_next = 1'b0;
            end
        end
        if (clr_cnt_reg < AW'(FONT_BYTES))
        begin
            clr_byte = FONT_ROM[clr_cnt_reg[6:0]];
        end
        else
        begin
            clr_byte = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Storage array and read register
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            mem[clr_cnt_reg] <= clr_byte;
        end
        else if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_reg;
endmodule

FILE: hdl/c8core_regs.sv
// ----------------------------------------------------------------------------
// c8core_regs
// V0..VF register file, single port with registered read. Per-entry valid
// bits give the zero reset value without a clearing pass.
// ----------------------------------------------------------------------------
module c8core_regs
    import c8core_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mem_cmd_t   cmd,
    input  logic [3:0] raddr,
    input  logic [3:0] waddr,
    input  logic [7:0] wdata,
    output logic [7:0] rdata
);
    logic [7:0]  regs [16];
    logic [15:0] vld_reg;
    logic [7:0]  rdata_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.wr)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // Array and read register
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            regs[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= vld_reg[raddr] ? regs[raddr] : 8'h00;
        end
    end

    assign rdata = rdata_reg;
endmodule
